@@ hdl/rau_pkg.sv @@
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

    localparam int FIELD_BITS = 32;

    typedef enum logic [2:0] {
        OP_REDUCE = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4
    } op_t;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,       // capture request operands
        CMD_MUL_AB,     // p = x * y, registered
        CMD_GCD_INIT,   // ga/gb = ordered x, y
        CMD_REM_START,  // start divider with ga rem gb
        CMD_REM_DONE,   // ga = gb, gb = remainder
        CMD_DIV_START,  // start divider with x / y
        CMD_MOVE,       // route selected value into a register
        CMD_FINISH      // unused; the datapath takes no action on it
    } cmd_t;

    typedef enum logic [3:0] {
        SEL_AN, SEL_AD, SEL_BN, SEL_BD, SEL_P, SEL_Q, SEL_GA, SEL_L,
        SEL_TA, SEL_SUM, SEL_ZERO
    } sel_t;

    typedef enum logic [2:0] {
        DST_X, DST_Y, DST_L, DST_TA, DST_TB, DST_RN, DST_RD, DST_G
    } dst_t;

    typedef struct packed {
        cmd_t cmd;
        sel_t sel_x;
        sel_t sel_y;
        dst_t dst;
        logic sub;
    } dp_ctrl_t;

    typedef struct packed {
        logic div_busy;
        logic div_zero;
        logic gb_zero;
    } dp_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DISPATCH,
        ST_GCD_INIT,
        ST_GCD_CHECK,
        ST_GCD_REM,
        ST_GCD_WAIT,
        ST_GCD_RET,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DIV_RET,
        ST_MUL,
        ST_MUL_RET,
        ST_STEP,
        ST_DONE,
        ST_OUT
    } state_t;

endpackage

@@ hdl/rau_divider.sv @@
// Radix-2 signed divider: truncating quotient and remainder, one bit a cycle.
module rau_divider
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] dividend,
    input  logic [WORD_BITS-1:0] divisor,
    output logic                 busy,
    output logic [WORD_BITS-1:0] quotient,
    output logic [WORD_BITS-1:0] remainder
);
    localparam int CW = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] q_reg, q_next;
    logic [WORD_BITS-1:0] d_reg, d_next;
    logic [WORD_BITS:0]   r_reg, r_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 qneg_reg, qneg_next, rneg_reg, rneg_next;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   shifted;

    always_comb begin
        q_next = q_reg;
        d_next = d_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        shifted = {r_reg[WORD_BITS-1:0], q_reg[WORD_BITS-1]};
        trial = shifted - {1'b0, d_reg};
        if (start) begin
            q_next = dividend[WORD_BITS-1] ? -dividend : dividend;
            d_next = divisor[WORD_BITS-1] ? -divisor : divisor;
            r_next = '0;
            cnt_next = CW'(WORD_BITS);
            busy_next = 1'b1;
            qneg_next = dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
            rneg_next = dividend[WORD_BITS-1];
        end else if (busy_reg) begin
            if (!trial[WORD_BITS]) begin
                r_next = trial;
                q_next = {q_reg[WORD_BITS-2:0], 1'b1};
            end else begin
                r_next = shifted;
                q_next = {q_reg[WORD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        d_reg <= d_next;
        r_reg <= r_next;
        cnt_reg <= cnt_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;
    assign quotient = qneg_reg ? -q_reg : q_reg;
    assign remainder = rneg_reg ? -r_reg[WORD_BITS-1:0] : r_reg[WORD_BITS-1:0];

endmodule

@@ hdl/rau_datapath.sv @@
// Datapath: operand registers, multiplier, gcd registers and shared divider.
module rau_datapath
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_ctrl_t              ctrl,
    input  logic [2:0]            req_type,
    input  logic [FIELD_BITS-1:0] a_num,
    input  logic [FIELD_BITS-1:0] a_den,
    input  logic [FIELD_BITS-1:0] b_num,
    input  logic [FIELD_BITS-1:0] b_den,
    output logic [2:0]            op,
    output dp_stat_t              stat,
    output logic [FIELD_BITS-1:0] res_num,
    output logic [FIELD_BITS-1:0] res_den
);
    typedef logic [WORD_BITS-1:0] word_t;

    word_t an_reg, ad_reg, bn_reg, bd_reg;
    word_t x_reg, y_reg, p_reg, ga_reg, gb_reg, l_reg, ta_reg, tb_reg;
    word_t rn_reg, rd_reg;
    logic [2:0] op_reg;
    word_t x_val, y_val, dq, dr;
    logic  dbusy;
    // products wrap, so only the low word is formed
    word_t prod;

    function automatic word_t from_field(input logic [FIELD_BITS-1:0] v);
        logic [FIELD_BITS+WORD_BITS-1:0] e;
        e = {{WORD_BITS{v[FIELD_BITS-1]}}, v};
        return e[WORD_BITS-1:0];
    endfunction

    function automatic logic [FIELD_BITS-1:0] to_field(input word_t v);
        logic [FIELD_BITS+WORD_BITS-1:0] e;
        e = {{FIELD_BITS{v[WORD_BITS-1]}}, v};
        return e[FIELD_BITS-1:0];
    endfunction

    function automatic word_t pick(input sel_t s, input word_t an, input word_t ad,
                                   input word_t bn, input word_t bd, input word_t p,
                                   input word_t q, input word_t ga, input word_t l,
                                   input word_t ta, input word_t sm);
        word_t r;
        case (s)
            SEL_AN:  r = an;
            SEL_AD:  r = ad;
            SEL_BN:  r = bn;
            SEL_BD:  r = bd;
            SEL_P:   r = p;
            SEL_Q:   r = q;
            SEL_GA:  r = ga;
            SEL_L:   r = l;
            SEL_TA:  r = ta;
            SEL_SUM: r = sm;
            default: r = '0;
        endcase
        return r;
    endfunction

    word_t sum_val;
    assign sum_val = ctrl.sub ? ta_reg - tb_reg : ta_reg + tb_reg;
    assign x_val = pick(ctrl.sel_x, an_reg, ad_reg, bn_reg, bd_reg, p_reg, dq, ga_reg,
                        l_reg, ta_reg, sum_val);
    assign y_val = pick(ctrl.sel_y, an_reg, ad_reg, bn_reg, bd_reg, p_reg, dq, ga_reg,
                        l_reg, ta_reg, sum_val);
    assign prod = x_reg * y_reg;

    logic  dstart;
    word_t ddvd, ddvs;
    always_comb begin
        dstart = 1'b0;
        ddvd = x_reg;
        ddvs = y_reg;
        if (ctrl.cmd == CMD_REM_START) begin
            dstart = 1'b1;
            ddvd = ga_reg;
            ddvs = gb_reg;
        end else if (ctrl.cmd == CMD_DIV_START) begin
            dstart = 1'b1;
        end
    end

    rau_divider #(.WORD_BITS(WORD_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (dstart),
        .dividend  (ddvd),
        .divisor   (ddvs),
        .busy      (dbusy),
        .quotient  (dq),
        .remainder (dr)
    );

    always_ff @(posedge aclk) begin
        case (ctrl.cmd)
            CMD_LOAD: begin
                op_reg <= req_type;
                an_reg <= from_field(a_num);
                ad_reg <= from_field(a_den);
                bn_reg <= from_field(b_num);
                bd_reg <= from_field(b_den);
            end
            CMD_MUL_AB: p_reg <= prod;
            CMD_GCD_INIT: begin
                if ($signed(x_reg) < $signed(y_reg)) begin
                    ga_reg <= y_reg;
                    gb_reg <= x_reg;
                end else begin
                    ga_reg <= x_reg;
                    gb_reg <= y_reg;
                end
            end
            CMD_REM_DONE: begin
                ga_reg <= gb_reg;
                gb_reg <= dr;
            end
            CMD_MOVE: begin
                case (ctrl.dst)
                    DST_X:  x_reg <= x_val;
                    DST_Y:  y_reg <= x_val;
                    DST_L:  l_reg <= x_val;
                    DST_TA: ta_reg <= x_val;
                    DST_TB: tb_reg <= x_val;
                    DST_RN: rn_reg <= x_val;
                    DST_RD: rd_reg <= x_val;
                    default: begin
                        x_reg <= x_val;
                        y_reg <= y_val;
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign op = op_reg;
    assign stat.div_busy = dbusy;
    assign stat.div_zero = (y_reg == '0);
    assign stat.gb_zero = (gb_reg == '0);
    assign res_num = to_field(rn_reg);
    assign res_den = to_field(rd_reg);

endmodule

@@ hdl/rau_controller.sv @@
// Controller: sequences gcd, divide and multiply steps for each request.
module rau_controller
    import rau_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  logic [2:0] op,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl,
    output logic     err
);
    state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       err_reg, err_next;
    // return target after a subroutine (gcd, divide, multiply)
    logic [4:0] ret_step;

    // Step program. Each step is one micro-operation; subroutines return to step+1.
    // Steps for add/sub:
    //  0 x=ad,y=bd  1 p=ad*bd  2 gcd->ga  3 x=p,y=ga  4 l=q, and so on.
    // Encoded below as a flat microprogram selected by op.
    typedef enum logic [2:0] {K_PAIR, K_GCD, K_MUL, K_DIV, K_MOVE, K_END} kind_t;

    typedef struct packed {
        kind_t kind;
        sel_t  sx;
        sel_t  sy;
        dst_t  dst;
    } uop_t;

    localparam dst_t DST_PAIR = DST_G;

    function automatic uop_t prog(input logic [2:0] o, input logic [4:0] s);
        uop_t u;
        u = '{K_END, SEL_ZERO, SEL_ZERO, DST_X};
        if (o == OP_REDUCE) begin
            case (s)
                5'd0: u = '{K_PAIR, SEL_AN, SEL_AD, DST_PAIR};
                5'd1: u = '{K_GCD, SEL_ZERO, SEL_ZERO, DST_X};
                5'd2: u = '{K_PAIR, SEL_AN, SEL_GA, DST_PAIR};
                5'd3: u = '{K_DIV, SEL_Q, SEL_ZERO, DST_RN};
                5'd4: u = '{K_PAIR, SEL_AD, SEL_GA, DST_PAIR};
                5'd5: u = '{K_DIV, SEL_Q, SEL_ZERO, DST_RD};
                default: u = '{K_END, SEL_ZERO, SEL_ZERO, DST_X};
            endcase
        end else if (o == OP_ADD || o == OP_SUB) begin
            case (s)
                5'd0:  u = '{K_PAIR, SEL_AD, SEL_BD, DST_PAIR};
                5'd1:  u = '{K_MUL, SEL_ZERO, SEL_ZERO, DST_X};
                5'd2:  u = '{K_GCD, SEL_ZERO, SEL_ZERO, DST_X};
                5'd3:  u = '{K_PAIR, SEL_P, SEL_GA, DST_PAIR};
                5'd4:  u = '{K_DIV, SEL_Q, SEL_ZERO, DST_L};
                5'd5:  u = '{K_PAIR, SEL_AN, SEL_L, DST_PAIR};
                5'd6:  u = '{K_MUL, SEL_ZERO, SEL_ZERO, DST_X};
                5'd7:  u = '{K_PAIR, SEL_P, SEL_AD, DST_PAIR};
                5'd8:  u = '{K_DIV, SEL_Q, SEL_ZERO, DST_TA};
                5'd9:  u = '{K_PAIR, SEL_BN, SEL_L, DST_PAIR};
                5'd10: u = '{K_MUL, SEL_ZERO, SEL_ZERO, DST_X};
                5'd11: u = '{K_PAIR, SEL_P, SEL_BD, DST_PAIR};
                5'd12: u = '{K_DIV, SEL_Q, SEL_ZERO, DST_TB};
                5'd13: u = '{K_PAIR, SEL_SUM, SEL_L, DST_PAIR};
                5'd14: u = '{K_GCD, SEL_ZERO, SEL_ZERO, DST_X};
                5'd15: u = '{K_MOVE, SEL_GA, SEL_ZERO, DST_Y};
                5'd16: u = '{K_MOVE, SEL_SUM, SEL_ZERO, DST_X};
                5'd17: u = '{K_DIV, SEL_Q, SEL_ZERO, DST_RN};
                5'd18: u = '{K_PAIR, SEL_L, SEL_GA, DST_PAIR};
                5'd19: u = '{K_DIV, SEL_Q, SEL_ZERO, DST_RD};
                default: u = '{K_END, SEL_ZERO, SEL_ZERO, DST_X};
            endcase
        end else if (o == OP_MUL) begin
            case (s)
                5'd0: u = '{K_PAIR, SEL_AN, SEL_BN, DST_PAIR};
                5'd1: u = '{K_MUL, SEL_ZERO, SEL_ZERO, DST_X};
                5'd2: u = '{K_MOVE, SEL_P, SEL_ZERO, DST_RN};
                5'd3: u = '{K_PAIR, SEL_AD, SEL_BD, DST_PAIR};
                5'd4: u = '{K_MUL, SEL_ZERO, SEL_ZERO, DST_X};
                5'd5: u = '{K_MOVE, SEL_P, SEL_ZERO, DST_RD};
                default: u = '{K_END, SEL_ZERO, SEL_ZERO, DST_X};
            endcase
        end else if (o == OP_DIV) begin
            case (s)
                5'd0: u = '{K_PAIR, SEL_AN, SEL_BD, DST_PAIR};
                5'd1: u = '{K_MUL, SEL_ZERO, SEL_ZERO, DST_X};
                5'd2: u = '{K_MOVE, SEL_P, SEL_ZERO, DST_RN};
                5'd3: u = '{K_PAIR, SEL_AD, SEL_BN, DST_PAIR};
                5'd4: u = '{K_MUL, SEL_ZERO, SEL_ZERO, DST_X};
                5'd5: u = '{K_MOVE, SEL_P, SEL_ZERO, DST_RD};
                default: u = '{K_END, SEL_ZERO, SEL_ZERO, DST_X};
            endcase
        end
        return u;
    endfunction

    uop_t uop;
    logic bad_op;
    assign uop = prog(op, step_reg);
    assign bad_op = !(op == OP_REDUCE || op == OP_ADD || op == OP_SUB ||
                      op == OP_MUL || op == OP_DIV);
    assign ret_step = step_reg + 5'd1;

    // next state
    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        err_next = err_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                step_next = '0;
                err_next = 1'b0;
                state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                if (bad_op) begin
                    err_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    unique case (uop.kind)
                        K_PAIR, K_MOVE: begin
                            step_next = ret_step;
                        end
                        K_GCD:  state_next = ST_GCD_INIT;
                        K_MUL:  state_next = ST_MUL;
                        K_DIV:  state_next = ST_DIV_START;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_GCD_INIT:  state_next = ST_GCD_CHECK;
            ST_GCD_CHECK: state_next = stat.gb_zero ? ST_GCD_RET : ST_GCD_REM;
            ST_GCD_REM:   state_next = ST_GCD_WAIT;
            ST_GCD_WAIT: begin
                if (!stat.div_busy) begin
                    state_next = ST_GCD_CHECK;
                end
            end
            ST_GCD_RET: begin
                step_next = ret_step;
                state_next = ST_DISPATCH;
            end
            ST_DIV_START: begin
                if (stat.div_zero) begin
                    err_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (!stat.div_busy) begin
                    state_next = ST_DIV_RET;
                end
            end
            ST_DIV_RET: begin
                step_next = ret_step;
                state_next = ST_DISPATCH;
            end
            ST_MUL: state_next = ST_MUL_RET;
            ST_MUL_RET: begin
                step_next = ret_step;
                state_next = ST_DISPATCH;
            end
            ST_STEP: state_next = ST_DISPATCH;
            ST_DONE: state_next = ST_OUT;
            ST_OUT: begin
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctrl = '{CMD_NONE, SEL_ZERO, SEL_ZERO, DST_X, op == OP_SUB};
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_LOAD: ctrl.cmd = CMD_LOAD;
            ST_DISPATCH: begin
                if (!bad_op && (uop.kind == K_PAIR || uop.kind == K_MOVE)) begin
                    ctrl.cmd = CMD_MOVE;
                    ctrl.sel_x = uop.sx;
                    ctrl.sel_y = uop.sy;
                    ctrl.dst = uop.dst;
                end
            end
            ST_GCD_INIT: ctrl.cmd = CMD_GCD_INIT;
            ST_GCD_REM:  ctrl.cmd = CMD_REM_START;
            ST_GCD_WAIT: begin
                if (!stat.div_busy) begin
                    ctrl.cmd = CMD_REM_DONE;
                end
            end
            ST_DIV_START: begin
                if (!stat.div_zero) begin
                    ctrl.cmd = CMD_DIV_START;
                end
            end
            ST_DIV_RET: begin
                ctrl.cmd = CMD_MOVE;
                ctrl.sel_x = uop.sx;
                ctrl.dst = uop.dst;
            end
            ST_MUL: ctrl.cmd = CMD_MUL_AB;
            ST_DONE: begin
                if (err_reg) begin
                    ctrl.cmd = CMD_MOVE;
                    ctrl.sel_x = SEL_ZERO;
                    ctrl.dst = DST_RN;
                end
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (err_reg) begin
                    ctrl.cmd = CMD_MOVE;
                    ctrl.sel_x = SEL_ZERO;
                    ctrl.dst = DST_RD;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        err_reg <= err_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign err = err_reg;

`ifndef SYNTH
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && out_valid))
        else $error("input and output handshakes overlap");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before taken");
    a_load_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> state_reg == ST_LOAD)
        else $error("accepted request not loaded");
`endif

endmodule

@@ hdl/rational_arithmetic_unit_top.sv @@
// Top level of the rational arithmetic unit: controller, datapath and ports.
//
//  channel | direction | tdata fields (low bit up)
//  s_axis  | in        | a_num, a_den, b_num, b_den; tuser = req_type
//  m_axis  | out       | res_num, res_den; tuser = div_error
//
// One request at a time. Each gcd remainder and each quotient runs on the one shared
// radix-2 divider; multiply and divide use only the multiplier.
// Reset is synchronous; the result holds on m_axis until m_axis_tready.
module rational_arithmetic_unit_top
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // a_num, a_den, b_num, b_den
    input  logic [2:0]   s_axis_tuser,   // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // res_num, res_den
    output logic         m_axis_tuser    // div_error
);
    dp_ctrl_t ctrl;
    dp_stat_t stat;
    logic [2:0] op;
    logic       err;
    logic [FIELD_BITS-1:0] rn, rd;

    rau_controller u_ctl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .op        (op),
        .stat      (stat),
        .ctrl      (ctrl),
        .err       (err)
    );

    // load comes in the cycle after accept, so capture the request on accept
    logic [127:0] req_reg;
    logic [2:0]   type_reg;
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            req_reg <= s_axis_tdata;
            type_reg <= s_axis_tuser;
        end
    end

    rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .req_type (type_reg),
        .a_num    (req_reg[31:0]),
        .a_den    (req_reg[63:32]),
        .b_num    (req_reg[95:64]),
        .b_den    (req_reg[127:96]),
        .op       (op),
        .stat     (stat),
        .res_num  (rn),
        .res_den  (rd)
    );

    assign m_axis_tdata = err ? 64'd0 : {rd, rn};
    assign m_axis_tuser = err;

endmodule

@@ verif/rational_arithmetic_unit_top_test.sv @@
// Self-checking test of the rational arithmetic unit: stream driver, monitor and fraction predictor.
module rational_arithmetic_unit_top_test;
    import rau_pkg::*;

    localparam int WDOG_LIMIT = 200000;
    localparam int NUM_RANDOM = 170;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] an;
        logic [31:0] ad;
        logic [31:0] bn;
        logic [31:0] bd;
    } frac_req_t;

    typedef struct packed {
        logic [31:0] rn;
        logic [31:0] rd;
        logic        err;
    } frac_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tuser;

    frac_req_t pending_reqs[$];
    frac_res_t expected_fracs[$];
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        hold_off = 0;
    int        errors = 0;
    int        reqs_sent = 0;
    int        results_seen = 0;
    int        quiet_cycles = 0;

    rational_arithmetic_unit_top uut (.*);

    always #10 aclk = ~aclk;

    function automatic logic [31:0] mag32(logic [31:0] x);
        return x[31] ? -x : x;
    endfunction

    function automatic logic [31:0] quot32(logic [31:0] a, logic [31:0] b, ref bit err);
        logic [31:0] q;
        if (b == 0) begin
            err = 1;
            return 0;
        end
        q = mag32(a) / mag32(b);
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] rem32(logic [31:0] a, logic [31:0] b);
        logic [31:0] r;
        r = mag32(a) % mag32(b);
        return a[31] ? -r : r;
    endfunction

    function automatic logic [31:0] euclid_gcd(logic [31:0] a, logic [31:0] b);
        logic [31:0] t;
        if ($signed(a) < $signed(b)) begin
            t = a;
            a = b;
            b = t;
        end
        while (b != 0) begin
            t = rem32(a, b);
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic frac_res_t predict_fraction(frac_req_t r);
        frac_res_t   o;
        bit          err;
        logic [31:0] g, l, ta, tb, s;
        err = 0;
        o = '0;
        case (r.op)
            OP_REDUCE: begin
                g = euclid_gcd(r.an, r.ad);
                o.rn = quot32(r.an, g, err);
                o.rd = quot32(r.ad, g, err);
            end
            OP_ADD, OP_SUB: begin
                l = quot32(r.ad * r.bd, euclid_gcd(r.ad, r.bd), err);
                ta = quot32(r.an * l, r.ad, err);
                tb = quot32(r.bn * l, r.bd, err);
                s = (r.op == OP_ADD) ? ta + tb : ta - tb;
                g = euclid_gcd(s, l);
                o.rn = quot32(s, g, err);
                o.rd = quot32(l, g, err);
            end
            OP_MUL: begin
                o.rn = r.an * r.bn;
                o.rd = r.ad * r.bd;
            end
            OP_DIV: begin
                o.rn = r.an * r.bd;
                o.rd = r.ad * r.bn;
            end
            default: err = 1;
        endcase
        if (err) begin
            o.rn = 0;
            o.rd = 0;
        end
        o.err = err;
        return o;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20);
            1: return -$urandom_range(1, 20);
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return $urandom_range(0, 4000) - 2000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_req(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        frac_req_t r;
        r = '{op, an, ad, bn, bd};
        pending_reqs.push_back(r);
    endtask

    // driver
    always @(posedge aclk) begin
        frac_req_t r;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                r = pending_reqs.pop_front();
                expected_fracs.push_back(predict_fraction(r));
                reqs_sent++;
            end
            if ((!s_axis_tvalid || s_axis_tready) && pending_reqs.size() > 0) begin
                if ($urandom_range(0, 99) >= idle_pct) begin
                    r = pending_reqs[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {r.bd, r.bn, r.ad, r.an};
                    s_axis_tuser  <= r.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end else if (!s_axis_tvalid || s_axis_tready) begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge aclk) begin
        frac_res_t want, got;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser};
                results_seen++;
                if (expected_fracs.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = expected_fracs.pop_front();
                    if (got.rn !== want.rn) begin
                        $display("%0t: res_num expected %h actual %h", $time, want.rn, got.rn);
                        errors++;
                    end
                    if (got.rd !== want.rd) begin
                        $display("%0t: res_den expected %h actual %h", $time, want.rd, got.rd);
                        errors++;
                    end
                    if (got.err !== want.err) begin
                        $display("%0t: div_error expected %b actual %b", $time, want.err,
                                 got.err);
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", WDOG_LIMIT);
            $display("** rational_arithmetic_unit_top: FAILED **");
            $finish;
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_fracs.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        int n;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: each operation, zero divisors, extremes, unused codes
        queue_req(OP_REDUCE, 12, 18, 0, 0);
        queue_req(OP_REDUCE, -12, 18, 5, 7);
        queue_req(OP_REDUCE, 0, 0, 0, 0);
        queue_req(OP_REDUCE, 5, 0, 0, 0);
        queue_req(OP_REDUCE, 32'h8000_0000, -1, 0, 0);
        queue_req(OP_REDUCE, 32'h7fff_ffff, 32'h8000_0000, -1, -1);
        queue_req(OP_ADD, 1, 2, 1, 3);
        queue_req(OP_ADD, 1, 0, 1, 3);
        queue_req(OP_ADD, -1, 4, 3, -6);
        queue_req(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        queue_req(OP_SUB, 3, 4, 1, 4);
        queue_req(OP_SUB, 1, 3, 1, 0);
        queue_req(OP_SUB, 32'h8000_0000, -1, 32'hffff_ffff, 1);
        queue_req(OP_MUL, 3, 4, 5, 7);
        queue_req(OP_MUL, 32'h7fff_ffff, 0, 32'h8000_0000, 32'hffff_ffff);
        queue_req(OP_DIV, 3, 4, 5, 7);
        queue_req(OP_DIV, 1, 2, 0, 0);
        queue_req(3'd5, 1, 2, 3, 4);
        queue_req(3'd6, 0, 0, 0, 0);
        queue_req(3'd7, -1, -1, -1, -1);
        drain();

        // random phases with different idle and stall mixes
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 37 : 0;
            stall_pct = (ph == 2) ? 60 : (ph == 3) ? 37 : 0;
            if (ph == 2)
                hold_off = 8000;
            for (n = 0; n < NUM_RANDOM / 4; n++)
                queue_req(3'($urandom_range(0, 9) == 0 ? $urandom_range(5, 7)
                                                        : $urandom_range(0, 4)),
                          rand_word(), rand_word(), rand_word(), rand_word());
            drain();
        end
        repeat (50) @(posedge aclk);

        $display("Sent %0d requests over all operations, zero divisors and unused codes;",
                 reqs_sent);
        $display("checked %0d results under idle, stall and long hold-off phases.",
                 results_seen);
        if (errors == 0)
            $display("** rational_arithmetic_unit_top: PASSED **");
        else
            $display("** rational_arithmetic_unit_top: FAILED **");
        $finish;
    end

endmodule
